### src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons)

`endif

`endif

### src/widal_pkg.sv
// Types, constants and register codes of the wheel report filter.
package widal_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 3;
   localparam int BYTE_W                = 8;
   localparam int BUTTON_BYTES          = 3;
   localparam int CONTROL_BYTES         = 8;
   localparam int AXIS_LANES            = 2;
   localparam int REPORT_BYTES          = BUTTON_BYTES + CONTROL_BYTES;
   localparam int REPORT_W              = REPORT_BYTES * BYTE_W;
   localparam int BUTTON_W              = BUTTON_BYTES * BYTE_W;
   localparam int CSR_INDEX_W           = 2;

   // Byte positions within a report, lowest first.
   localparam int BTN0 = 0;
   localparam int BTN1 = 1;
   localparam int BTN2 = 2;
   localparam int CTL0 = 3;
   localparam int CTL1 = 4;
   localparam int CTL2 = 5;
   localparam int CTL3 = 6;
   localparam int CTL4 = 7;
   localparam int CTL5 = 8;
   localparam int CTL6 = 9;
   localparam int CTL7 = 10;

   localparam logic [BYTE_W-1:0] NIBBLE_MASK  = 8'h0f;
   localparam logic [BYTE_W-1:0] LATCH_BTN_A  = 8'h01;
   localparam logic [BYTE_W-1:0] LATCH_BTN_B  = 8'h08;
   localparam logic [BYTE_W-1:0] LATCH_FLAG_A = 8'h01;
   localparam logic [BYTE_W-1:0] LATCH_FLAG_B = 8'h02;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LATCH_ENABLE  = 2'd0,
      CSR_EXPAND_ENABLE = 2'd1
   } csr_index_type;

   typedef logic [REPORT_BYTES-1:0][BYTE_W-1:0] report_type;
   typedef logic [AXIS_LANES-1:0][BYTE_W-1:0]   axis_type;

   typedef struct packed {
      logic latch_enable;
      logic expand_enable;
   } cfg_type;

endpackage

### src/widal_history.sv
// Ring history of button and axis samples with AND and sum reduction.
module widal_history import widal_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           wr_en,
   input  logic [BUTTON_W-1:0]                            button_in,
   input  axis_type                                       axis_in,
   output logic [BUTTON_W-1:0]                            button_and,
   output logic [AXIS_LANES-1:0][BYTE_W+$clog2(HISTORY_DEPTH)-1:0] axis_sum
);

   localparam int SumW  = BYTE_W + $clog2(HISTORY_DEPTH);
   localparam int SlotW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   logic [HISTORY_DEPTH-1:0][BUTTON_W-1:0] btn_hist_ff;
   axis_type [HISTORY_DEPTH-1:0]           axis_hist_ff;
   logic [SlotW-1:0]                       slot_ff;
   logic [SlotW-1:0]                       slot_in;

   // Current sample takes the place of the slot it overwrites.
   always_comb begin
      logic [BUTTON_W-1:0] btn_acc;
      logic [AXIS_LANES-1:0][SumW-1:0] sum_acc;
      btn_acc = '1;
      sum_acc = '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
         if (slot_ff == SlotW'(k)) begin
            btn_acc = btn_acc & button_in;
            for (int i = 0; i < AXIS_LANES; i++) begin
               sum_acc[i] = sum_acc[i] + SumW'(axis_in[i]);
            end
         end else begin
            btn_acc = btn_acc & btn_hist_ff[k];
            for (int i = 0; i < AXIS_LANES; i++) begin
               sum_acc[i] = sum_acc[i] + SumW'(axis_hist_ff[k][i]);
            end
         end
      end
      button_and = btn_acc;
      axis_sum   = sum_acc;
   end

   always_comb begin
      slot_in = slot_ff;
      if (wr_en) begin
         if (slot_ff == SlotW'(HISTORY_DEPTH - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         btn_hist_ff  <= '0;
         axis_hist_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            if (wr_en && slot_ff == SlotW'(k)) begin
               btn_hist_ff[k]  <= button_in;
               axis_hist_ff[k] <= axis_in;
            end
         end
      end
   end

endmodule

### src/widal_calc.sv
// Mean by reciprocal multiply, nibble expansion and button latching.
module widal_calc import widal_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  report_type                                             report_in,
   input  logic                                                   pending,
   input  cfg_type                                                cfg,
   input  logic [BUTTON_W-1:0]                                    button_and,
   input  logic [AXIS_LANES-1:0][BYTE_W+$clog2(HISTORY_DEPTH)-1:0] axis_sum,
   output report_type                                             result
);

   localparam int SumW   = BYTE_W + $clog2(HISTORY_DEPTH);
   localparam int Shift  = 16;
   localparam int RecipW = Shift + 1;
   localparam int ProdW  = SumW + RecipW;
   // Rounded-up reciprocal; exact floor for sums below 2^11 and depth up to 8.
   localparam longint Recip = ((longint'(1) << Shift) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

   logic [AXIS_LANES-1:0][ProdW-1:0] prod;

   always_comb begin
      for (int i = 0; i < AXIS_LANES; i++) begin
         prod[i] = ProdW'(axis_sum[i]) * ProdW'(Recip);
      end
   end

   always_comb begin
      logic [BYTE_W-1:0] btn1;
      logic [BYTE_W-1:0] ctl3;
      result = report_in;
      result[BTN0] = button_and[BTN0*BYTE_W +: BYTE_W];
      result[BTN2] = button_and[BTN2*BYTE_W +: BYTE_W];
      result[CTL4] = prod[0][Shift +: BYTE_W];
      result[CTL5] = prod[1][Shift +: BYTE_W];

      if (cfg.expand_enable) begin
         result[CTL0] = report_in[CTL7] & NIBBLE_MASK;
         result[CTL1] = {4'h0, report_in[CTL7][BYTE_W-1:4]};
      end

      // Set a flag on press; restore the button from a flag already set.
      btn1 = button_and[BTN1*BYTE_W +: BYTE_W];
      ctl3 = report_in[CTL3];
      if (cfg.latch_enable && !pending) begin
         if ((btn1 & LATCH_BTN_A) != '0) begin
            ctl3 = ctl3 | LATCH_FLAG_A;
         end else if ((ctl3 & LATCH_FLAG_A) != '0) begin
            btn1 = btn1 | LATCH_BTN_A;
         end
         if ((btn1 & LATCH_BTN_B) != '0) begin
            ctl3 = ctl3 | LATCH_FLAG_B;
         end else if ((ctl3 & LATCH_FLAG_B) != '0) begin
            btn1 = btn1 | LATCH_BTN_B;
         end
      end
      result[BTN1] = btn1;
      result[CTL3] = ctl3;
   end

endmodule

### src/wheel_input_debounce_average_latch.sv
// Top level of the wheel report debounce, average and latch filter.
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  tdata: 11 report bytes, tuser: pending
//   rsp_     out        rsp_tvalid/rsp_tready  tdata: 11 filtered bytes
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data (bit 0)
//
// One item per cycle sustained while rsp_tready holds; an accepted item passes
// through the input register, then the result register, which drives rsp_tvalid.
// The input register feeds the history reduction, the divide-by-depth multiply and
// the latch logic in one pass into the result register.
// Reset (synchronous) clears the history, the ring slot and both valid bits; latch
// off, expand on. A stalled result holds the result register; the input register
// still takes an item and waits, so the input side stalls only when both are full.
`include "assert_macros.svh"

module wheel_input_debounce_average_latch import widal_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // bits from low: button_byte0..2, control_byte0..7
   input  logic [REPORT_W-1:0]    req_tdata,
   // bit 0: transition_pending
   input  logic                   req_tuser,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // bits from low: out_button0..2, out_control0..3, out_axis_first,
   // out_axis_second, out_control6, out_control7
   output logic [REPORT_W-1:0]    rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_data
);

   localparam int SumW = BYTE_W + $clog2(HISTORY_DEPTH);

   // Input register.
   logic       a_valid_ff;
   logic       a_valid_in;
   report_type a_data_ff;
   logic       a_pending_ff;

   // Result register.
   logic       b_valid_ff;
   logic       b_valid_in;
   report_type b_data_ff;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;

   logic       req_accept;
   logic       advance_a;

   logic [BUTTON_W-1:0]               button_and;
   logic [AXIS_LANES-1:0][SumW-1:0]   axis_sum;
   axis_type                          axis_now;
   report_type                        result;

   // Move the input item forward whenever the result register is free or draining.
   assign advance_a  = a_valid_ff && (!b_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || advance_a;
   assign req_accept = req_tvalid && req_tready;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_data_ff;

   assign axis_now[0] = a_data_ff[CTL4];
   assign axis_now[1] = a_data_ff[CTL5];

   widal_history #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_history (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (advance_a),
      .button_in  (a_data_ff[BTN2:BTN0]),
      .axis_in    (axis_now),
      .button_and (button_and),
      .axis_sum   (axis_sum)
   );

   widal_calc #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_calc (
      .report_in  (a_data_ff),
      .pending    (a_pending_ff),
      .cfg        (cfg_ff),
      .button_and (button_and),
      .axis_sum   (axis_sum),
      .result     (result)
   );

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (advance_a) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (advance_a) begin
         b_valid_in = 1'b1;
      end else if (rsp_tready) begin
         b_valid_in = 1'b0;
      end
   end

   // Decode register writes; drop writes to unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LATCH_ENABLE:  cfg_in.latch_enable  = csr_data;
            CSR_EXPAND_ENABLE: cfg_in.expand_enable = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff           <= 1'b0;
         b_valid_ff           <= 1'b0;
         cfg_ff.latch_enable  <= 1'b0;
         cfg_ff.expand_enable <= 1'b1;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         cfg_ff     <= cfg_in;
      end
   end

   // Payload: load the input on accept, the result on advance; hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_data_ff    <= req_tdata;
         a_pending_ff <= req_tuser;
      end
      if (advance_a) begin
         b_data_ff <= result;
      end
   end

   `ASSERT_SAME_CYCLE(ready_when_input_empty, clock, reset, !a_valid_ff, req_tready)
   `ASSERT_NEXT_CYCLE(input_holds_when_blocked, clock, reset,
                      a_valid_ff && !advance_a, a_valid_ff)
   `ASSERT_NEXT_CYCLE(advance_fills_result, clock, reset, advance_a, b_valid_ff)

endmodule

### sim/tb_wheel_input_debounce_average_latch.sv
// Self-checking testbench for the wheel report debounce, average and latch filter.
`timescale 1ns / 100ps

module tb_wheel_input_debounce_average_latch;
   import widal_pkg::*;

   localparam int HIST           = HISTORY_DEPTH_DEFAULT;
   localparam int PIPE_LATENCY   = 2;
   localparam int MAX_WAIT       = 10;
   localparam int STALL_LIMIT    = 2000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_REPORTS  = 250;
   localparam int PRINT_LIMIT    = 40;
   // first index past the register list; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LOW = CSR_EXPAND_ENABLE + 1'b1;

   logic                   clock;
   logic                   reset;
   logic [REPORT_W-1:0]    req_tdata;   // bits from low: button_byte0..2, control_byte0..7
   logic                   req_tuser;   // bit 0: transition_pending
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REPORT_W-1:0]    rsp_tdata;   // bits from low: out_button0..2, out_control0..3,
                                        // out_axis_first, out_axis_second, out_control6..7
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_data;

   // Filter state as the block should hold it.
   logic [BYTE_W-1:0] button_hist [HIST][BUTTON_BYTES] = '{default: '0};
   logic [BYTE_W-1:0] axis_hist   [HIST][AXIS_LANES]   = '{default: '0};
   int                ring_slot   = 0;
   logic              latch_on    = 1'b0;
   logic              expand_on   = 1'b1;

   report_type filtered_reports [$];
   int         error_count = 0;
   bit         no_idle     = 1'b0;
   string      field_name [REPORT_BYTES] = '{"out_button0", "out_button1", "out_button2",
      "out_control0", "out_control1", "out_control2", "out_control3", "out_axis_first",
      "out_axis_second", "out_control6", "out_control7"};

   wheel_input_debounce_average_latch uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t ns: %s", $time, msg);
      end
      error_count++;
   endtask

   // Advance the filter state by one report and return the filtered report.
   function automatic report_type filter_report(input report_type rep, input logic pending);
      report_type        res;
      logic [BYTE_W-1:0] acc;
      int unsigned       total;
      res = rep;
      // debounce: a bit survives only if set in every history slot
      for (int b = 0; b < BUTTON_BYTES; b++) begin
         button_hist[ring_slot][b] = rep[BTN0 + b];
         acc = '1;
         for (int k = 0; k < HIST; k++) begin
            acc &= button_hist[k][b];
         end
         res[BTN0 + b] = acc;
      end
      // floor mean of the two axis lanes, unwritten slots count as zero
      for (int a = 0; a < AXIS_LANES; a++) begin
         axis_hist[ring_slot][a] = rep[CTL4 + a];
         total = 0;
         for (int k = 0; k < HIST; k++) begin
            total += axis_hist[k][a];
         end
         res[CTL4 + a] = BYTE_W'(total / HIST);
      end
      ring_slot = (ring_slot + 1) % HIST;
      if (expand_on) begin
         res[CTL0] = rep[CTL7] & NIBBLE_MASK;
         res[CTL1] = rep[CTL7] >> 4;
      end
      // latch: a pressed button sets its flag, a set flag restores its button
      if (latch_on && !pending) begin
         if ((res[BTN1] & LATCH_BTN_A) != '0) begin
            res[CTL3] |= LATCH_FLAG_A;
         end else if ((res[CTL3] & LATCH_FLAG_A) != '0) begin
            res[BTN1] |= LATCH_BTN_A;
         end
         if ((res[BTN1] & LATCH_BTN_B) != '0) begin
            res[CTL3] |= LATCH_FLAG_B;
         end else if ((res[CTL3] & LATCH_FLAG_B) != '0) begin
            res[BTN1] |= LATCH_BTN_B;
         end
      end
      return res;
   endfunction

   // Fill the free-running bytes (controls 0, 1, 2, 6) at random.
   function automatic report_type build_report(input logic [BYTE_W-1:0] btn0, btn1, btn2,
                                               ctl3, axis0, axis1, ctl7);
      report_type rep;
      rep       = REPORT_W'({$urandom, $urandom, $urandom});
      rep[BTN0] = btn0;
      rep[BTN1] = btn1;
      rep[BTN2] = btn2;
      rep[CTL3] = ctl3;
      rep[CTL4] = axis0;
      rep[CTL5] = axis1;
      rep[CTL7] = ctl7;
      return rep;
   endfunction

   // Send one item; valid stays high after acceptance so back-to-back items
   // need no second assignment in the same step.
   task automatic send_report(input report_type rep, input logic pending);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rep;
      req_tuser  <= pending;
      do @(posedge clock); while (!req_tready);
      filtered_reports.push_back(filter_report(rep, pending));
   endtask

   // Drop valid and hold until every expected item has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (filtered_reports.size() != 0);
   endtask

   // Write an unused index, then both registers, keeping valid high throughout.
   task automatic apply_settings(input logic latch_val, input logic expand_val);
      logic [CSR_INDEX_W-1:0] idx  [3];
      logic                   vals [3];
      idx[0]  = CSR_UNUSED_LOW + CSR_INDEX_W'($urandom_range(0, 1));
      vals[0] = 1'($urandom);
      idx[1]  = CSR_LATCH_ENABLE;
      vals[1] = latch_val;
      idx[2]  = CSR_EXPAND_ENABLE;
      vals[2] = expand_val;
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         if (idx[i] == CSR_LATCH_ENABLE) begin
            latch_on = vals[i];
         end else if (idx[i] == CSR_EXPAND_ENABLE) begin
            expand_on = vals[i];
         end
      end
      csr_valid <= 1'b0;
   endtask

   // Zeroed history right after reset: buttons read released, means ramp up.
   task automatic test_startup_history();
      for (int i = 0; i < 4; i++) begin
         send_report(build_report(8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'h5a), 1'b0);
      end
   endtask

   // All-zero and all-one reports, nibble patterns of control 7, both pending values.
   task automatic test_extremes();
      send_report(build_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
      send_report(build_report(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 1'b1);
      send_report(build_report(8'haa, 8'h55, 8'hf0, 8'hfc, 8'hfe, 8'h01, 8'ha5), 1'b0);
      send_report(build_report(8'h55, 8'haa, 8'h0f, 8'h03, 8'h01, 8'hfe, 8'h5a), 1'b1);
   endtask

   // Expand off: controls 0 and 1 pass through.
   task automatic test_expand_off();
      wait_drained();
      apply_settings(1'b0, 1'b0);
      send_report(build_report(8'hff, 8'hff, 8'hff, 8'h00, 8'h80, 8'h7f, 8'hc3), 1'b0);
      send_report(build_report(8'hff, 8'hff, 8'hff, 8'h00, 8'h80, 8'h7f, 8'h3c), 1'b0);
   endtask

   // Latch on: set flags from held buttons, restore released buttons from flags,
   // suspend on a pending transition, keep a pressed button with its flag set.
   task automatic test_latch_buttons();
      wait_drained();
      apply_settings(1'b1, 1'b1);
      for (int i = 0; i < 3; i++) begin
         send_report(build_report(8'h00, LATCH_BTN_A | LATCH_BTN_B, 8'h00, 8'h00,
                                  8'h10, 8'h20, 8'h00), 1'b0);
      end
      send_report(build_report(8'h00, 8'h00, 8'h00, LATCH_FLAG_A | LATCH_FLAG_B,
                               8'h10, 8'h20, 8'h00), 1'b0);
      send_report(build_report(8'h00, 8'h00, 8'h00, LATCH_FLAG_A, 8'h10, 8'h20, 8'h00), 1'b0);
      send_report(build_report(8'h00, 8'h00, 8'h00, LATCH_FLAG_B, 8'h10, 8'h20, 8'h00), 1'b0);
      send_report(build_report(8'h00, 8'h00, 8'h00, LATCH_FLAG_A | LATCH_FLAG_B,
                               8'h10, 8'h20, 8'h00), 1'b1);
      for (int i = 0; i < 3; i++) begin
         send_report(build_report(8'h00, 8'hff, 8'h00, LATCH_FLAG_A | LATCH_FLAG_B,
                                  8'h10, 8'h20, 8'h00), 1'b0);
      end
   endtask

   // Random phases across all register settings. Buttons are mostly held with
   // occasional bit flips so debounced bits and latches see real activity.
   task automatic test_random_reports();
      logic [BYTE_W-1:0] held [BUTTON_BYTES];
      report_type        rep;
      logic              latch_val;
      logic              expand_val;
      for (int b = 0; b < BUTTON_BYTES; b++) begin
         held[b] = BYTE_W'($urandom);
      end
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         latch_val  = (p < 4) ? p[0] : 1'($urandom);
         expand_val = (p < 4) ? p[1] : 1'($urandom);
         apply_settings(latch_val, expand_val);
         for (int i = 0; i < PHASE_REPORTS; i++) begin
            if (i % 50 == 0) begin
               no_idle = ($urandom_range(0, 3) == 0);
            end
            rep = REPORT_W'({$urandom, $urandom, $urandom});
            if ($urandom_range(0, 9) < 7) begin
               for (int b = 0; b < BUTTON_BYTES; b++) begin
                  case ($urandom_range(0, 15))
                     0:       held[b] = '0;
                     1:       held[b] = '1;
                     2, 3, 4: held[b] ^= BYTE_W'(1) << $urandom_range(0, BYTE_W - 1);
                     default: held[b] = held[b];
                  endcase
                  rep[BTN0 + b] = held[b];
               end
            end
            // pull the axis samples to the rails now and then
            case ($urandom_range(0, 7))
               0:       rep[CTL4] = '0;
               1:       rep[CTL4] = '1;
               default: rep[CTL4] = rep[CTL4];
            endcase
            case ($urandom_range(0, 7))
               0:       rep[CTL5] = '0;
               1:       rep[CTL5] = '1;
               default: rep[CTL5] = rep[CTL5];
            endcase
            send_report(rep, ($urandom_range(0, 3) == 0));
         end
         no_idle = 1'b0;
      end
   endtask

   // Result side: draw a stall per item, then hold ready until one is taken.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare every accepted result with the oldest expected item.
   always @(posedge clock) begin
      report_type got;
      report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (filtered_reports.size() == 0) begin
            report_error($sformatf("result %h arrived with nothing expected", got));
         end else begin
            want = filtered_reports.pop_front();
            for (int f = 0; f < REPORT_BYTES; f++) begin
               if (got[f] !== want[f]) begin
                  report_error($sformatf("%s: got %h, expected %h",
                                         field_name[f], got[f], want[f]));
               end
            end
         end
      end
   end

   // End the run if no channel moves an item for too long.
   initial begin : watchdog
      int stalled_cycles;
      stalled_cycles = 0;
      do @(posedge clock); while (reset);
      while (stalled_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
      end
      $display("%0t ns: no progress for %0d cycles, %0d items outstanding",
               $time, STALL_LIMIT, filtered_reports.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_startup_history();
      test_extremes();
      test_expand_off();
      test_latch_buttons();
      test_random_reports();

      wait_drained();
      // let any stray result surface before the verdict
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
